[rtl/core/spring_force_generator_defines.svh]
// assertion macros used by the checker file
`ifndef SPRING_FORCE_GENERATOR_DEFINES_SVH
`define SPRING_FORCE_GENERATOR_DEFINES_SVH

// same-cycle implication
`define SFG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sfg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfg_pkg
// Register map and fixed widths of the spring force generator.
// ----------------------------------------------------------------------------
package sfg_pkg;

    localparam int CFG_W      = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [0:0] REG_STIFFNESS   = 1'b0;
    localparam logic [0:0] REG_REST_LENGTH = 1'b1;

    localparam logic [CFG_W-1:0] STIFFNESS_RESET = 32'd65536;
    localparam logic [CFG_W-1:0] REST_RESET      = 32'd0;

endpackage
`default_nettype wire

[rtl/core/sfg_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfg_sqrt
// Pipelined integer square root, one root bit per stage, payload alongside.
// ----------------------------------------------------------------------------
module sfg_sqrt #(
    parameter int RTW = 33,
    parameter int PW  = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [2*RTW-1:0] in_rad,
    input  wire logic [PW-1:0]    in_pay,
    output logic                  out_valid,
    output logic [RTW-1:0]        out_root,
    output logic [PW-1:0]         out_pay
);
    localparam int SQW = 2 * RTW;
    localparam int RMW = RTW + 1;

    logic           vld_reg  [1:RTW];
    logic [RTW-1:0] root_reg [1:RTW];
    logic [PW-1:0]  pay_reg  [1:RTW];
    logic [SQW-1:0] rad_reg  [1:RTW-1];
    logic [RMW-1:0] rem_reg  [1:RTW-1];

    for (genvar i = 0; i < RTW; i++) begin : g_st
        logic [SQW-1:0] rad_p;
        logic [RMW-1:0] rem_p;
        logic [RTW-1:0] root_p;
        logic [PW-1:0]  pay_p;
        logic           vld_p;
        logic [RMW+1:0] rem_sh;
        logic [RMW+1:0] trial;
        logic           ge;

        if (i == 0) begin : g_in
            assign rad_p  = in_rad;
            assign rem_p  = '0;
            assign root_p = '0;
            assign pay_p  = in_pay;
            assign vld_p  = in_valid;
        end else begin : g_mid
            assign rad_p  = rad_reg[i];
            assign rem_p  = rem_reg[i];
            assign root_p = root_reg[i];
            assign pay_p  = pay_reg[i];
            assign vld_p  = vld_reg[i];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_p, rad_p[SQW-1 -: 2]};
        assign trial  = {1'b0, root_p, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[i+1] <= {root_p[RTW-2:0], ge};
                pay_reg[i+1]  <= pay_p;
            end
        end

        if (i < RTW - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[i+1] <= rad_p << 2;
                    rem_reg[i+1] <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
                end
            end
        end
    end

    assign out_valid = vld_reg[RTW];
    assign out_root  = root_reg[RTW];
    assign out_pay   = pay_reg[RTW];

endmodule
`default_nettype wire

[rtl/core/sfg_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfg_div
// Three-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module sfg_div #(
    parameter int DENW = 49,
    parameter int QW   = 49,
    parameter int PW   = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [DENW-1:0]             in_den,
    input  wire logic [2:0][DENW+QW-1:0]     in_num,
    input  wire logic [PW-1:0]               in_pay,
    output logic                             out_valid,
    output logic [2:0][QW-1:0]               out_quo,
    output logic [PW-1:0]                    out_pay
);
    localparam int NW = DENW + QW;

    logic                   vld_reg [1:QW];
    logic [2:0][QW-1:0]     qn_reg  [1:QW];
    logic [PW-1:0]          pay_reg [1:QW];
    logic [DENW-1:0]        den_reg [1:QW-1];
    logic [2:0][DENW-1:0]   rem_reg [1:QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_st
        logic [DENW-1:0]      den_p;
        logic [2:0][DENW-1:0] rem_p;
        logic [2:0][QW-1:0]   qn_p;
        logic [PW-1:0]        pay_p;
        logic                 vld_p;
        logic [2:0][DENW-1:0] rem_n;
        logic [2:0][QW-1:0]   qn_n;

        if (i == 0) begin : g_in
            assign den_p = in_den;
            assign pay_p = in_pay;
            assign vld_p = in_valid;
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign rem_p[l] = in_num[l][NW-1:QW];
                assign qn_p[l]  = in_num[l][QW-1:0];
            end
        end else begin : g_mid
            assign den_p = den_reg[i];
            assign rem_p = rem_reg[i];
            assign qn_p  = qn_reg[i];
            assign pay_p = pay_reg[i];
            assign vld_p = vld_reg[i];
        end

        // numerator bits leave the top of qn as quotient bits enter below
        always_comb begin
            logic [DENW:0] rem_sh;
            logic          ge;
            for (int l = 0; l < 3; l++) begin
                rem_sh   = {rem_p[l], qn_p[l][QW-1]};
                ge       = (rem_sh >= {1'b0, den_p});
                rem_n[l] = ge ? DENW'(rem_sh - {1'b0, den_p}) : DENW'(rem_sh);
                qn_n[l]  = {qn_p[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_p;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                qn_reg[i+1]  <= qn_n;
                pay_reg[i+1] <= pay_p;
            end
        end

        if (i < QW - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[i+1] <= den_p;
                    rem_reg[i+1] <= rem_n;
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quo   = qn_reg[QW];
    assign out_pay   = pay_reg[QW];

endmodule
`default_nettype wire

[rtl/core/spring_force_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spring_force_generator
// Hooke spring force from two world-space end points, Q16.16 by default.
// ----------------------------------------------------------------------------
// The input channel (s_valid/s_ready) takes both end points of one spring per
// request; the result channel (m_valid/m_ready) returns the saturated force,
// the application point (end A) and a flag for coinciding ends. The user must
// write stiffness and rest length over the APB port only while no request is
// in flight; the block itself does not enforce it. One request is taken every
// cycle while the receiver does not stall. The pipeline has four stages of
// difference, square and sum, one stage per root bit of the square root, four
// stages of stretch products, one stage per quotient bit of the divider and
// the output stage. When the receiver stalls the whole pipeline holds; a
// one-entry skid buffer still takes the next request, and s_ready drops only
// while it is full. Reset clears all valid bits and the skid buffer and loads
// stiffness 1.0 and rest length 0; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module spring_force_generator #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfg_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sfg_pkg::CFG_W-1:0]       pwdata,
    output logic      [sfg_pkg::CFG_W-1:0]       prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]   s_end_a_x,
    input  wire logic signed [COORD_WIDTH-1:0]   s_end_a_y,
    input  wire logic signed [COORD_WIDTH-1:0]   s_end_a_z,
    input  wire logic signed [COORD_WIDTH-1:0]   s_end_b_x,
    input  wire logic signed [COORD_WIDTH-1:0]   s_end_b_y,
    input  wire logic signed [COORD_WIDTH-1:0]   s_end_b_z,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [COORD_WIDTH-1:0]        m_force_x,
    output logic signed [COORD_WIDTH-1:0]        m_force_y,
    output logic signed [COORD_WIDTH-1:0]        m_force_z,
    output logic signed [COORD_WIDTH-1:0]        m_apply_x,
    output logic signed [COORD_WIDTH-1:0]        m_apply_y,
    output logic signed [COORD_WIDTH-1:0]        m_apply_z,
    output logic                                 m_degenerate
);
    import sfg_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = CW + 1;
    localparam int DW   = (MW > CFG_W) ? MW : CFG_W;
    localparam int SW   = CFG_W + DW;
    localparam int NW   = SW + MW;
    localparam int DENW = MW + FRAC_BITS;
    localparam int QW   = SW - FRAC_BITS;

    typedef logic [2:0][CW-1:0] vec_t;

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         pos;
        vec_t               apply;
        logic               degen;
    } item_t;

    typedef struct packed {
        logic [2:0] pos;
        vec_t       apply;
        logic       degen;
    } tail_t;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] stiff_reg;
    logic [CFG_W-1:0] rest_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg <= STIFFNESS_RESET;
            rest_reg  <= REST_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_STIFFNESS:   stiff_reg <= pwdata;
                REG_REST_LENGTH: rest_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STIFFNESS:   prdata = stiff_reg;
            REG_REST_LENGTH: prdata = rest_reg;
            default:         prdata = '0;
        endcase
    end

    // ---------------- skid buffer ----------------
    logic pipe_en;
    logic skid_vld_reg;
    vec_t skid_a_reg;
    vec_t skid_b_reg;
    vec_t in_a;
    vec_t in_b;
    logic in_vld;

    assign pipe_en = m_ready || !m_valid;
    assign s_ready = !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_valid && !skid_vld_reg) begin
            skid_a_reg <= {s_end_a_z, s_end_a_y, s_end_a_x};
            skid_b_reg <= {s_end_b_z, s_end_b_y, s_end_b_x};
        end
    end

    assign in_vld = skid_vld_reg || s_valid;
    assign in_a   = skid_vld_reg ? skid_a_reg : {s_end_a_z, s_end_a_y, s_end_a_x};
    assign in_b   = skid_vld_reg ? skid_b_reg : {s_end_b_z, s_end_b_y, s_end_b_x};

    // ---------------- front stages ----------------
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [2:0][MW-1:0] d1_reg;
    vec_t               a1_reg, a2_reg, a3_reg;
    logic [2:0][MW-1:0] mag2_reg, mag3_reg;
    logic [2:0]         pos2_reg, pos3_reg;
    logic [2:0][2*MW-1:0] sq3_reg;
    logic [2*MW-1:0]    sum4_reg;
    item_t              item4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]   <= {in_a[i][CW-1], in_a[i]} - {in_b[i][CW-1], in_b[i]};
                mag2_reg[i] <= d1_reg[i][MW-1] ? MW'(-d1_reg[i]) : d1_reg[i];
                pos2_reg[i] <= !d1_reg[i][MW-1] && (d1_reg[i] != '0);
                sq3_reg[i]  <= (2*MW)'(mag2_reg[i]) * (2*MW)'(mag2_reg[i]);
            end
            a1_reg    <= in_a;
            a2_reg    <= a1_reg;
            a3_reg    <= a2_reg;
            mag3_reg  <= mag2_reg;
            pos3_reg  <= pos2_reg;
            sum4_reg  <= sq3_reg[0] + sq3_reg[1] + sq3_reg[2];
            item4_reg <= '{mag: mag3_reg, pos: pos3_reg, apply: a3_reg,
                           degen: (mag3_reg == '0)};
        end
    end

    // ---------------- length ----------------
    logic          sq_vld;
    logic [MW-1:0] len;
    item_t         sq_item;

    sfg_sqrt #(
        .RTW (MW),
        .PW  ($bits(item_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v4_reg),
        .in_rad    (sum4_reg),
        .in_pay    (item4_reg),
        .out_valid (sq_vld),
        .out_root  (len),
        .out_pay   (sq_item)
    );

    // ---------------- stretch and numerators ----------------
    logic                    v5_reg, v6_reg, v7_reg, v8_reg;
    logic [DW-1:0]           len_ext;
    logic [DW-1:0]           rest_ext;
    logic [DW-1:0]           delta5_reg;
    logic [MW-1:0]           len5_reg, len6_reg, len7_reg;
    item_t                   item5_reg, item6_reg;
    logic [SW-1:0]           stretch6_reg;
    logic [2:0][CFG_W+MW-1:0] pl7_reg;
    logic [2:0][DW+MW-1:0]   ph7_reg;
    tail_t                   tail7_reg, tail8_reg;
    logic [2:0][NW-1:0]      num8_reg;
    logic [DENW-1:0]         den8_reg;

    assign len_ext  = DW'(len);
    assign rest_ext = DW'(rest_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (pipe_en) begin
            v5_reg <= sq_vld;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            delta5_reg   <= (len_ext >= rest_ext) ? len_ext - rest_ext : rest_ext - len_ext;
            len5_reg     <= len;
            item5_reg    <= sq_item;
            stretch6_reg <= SW'(stiff_reg) * SW'(delta5_reg);
            len6_reg     <= len5_reg;
            item6_reg    <= item5_reg;
            // split the wide product into two narrower ones
            for (int i = 0; i < 3; i++) begin
                pl7_reg[i] <= (CFG_W+MW)'(stretch6_reg[CFG_W-1:0])
                              * (CFG_W+MW)'(item6_reg.mag[i]);
                ph7_reg[i] <= (DW+MW)'(stretch6_reg[SW-1:CFG_W])
                              * (DW+MW)'(item6_reg.mag[i]);
                num8_reg[i] <= NW'(pl7_reg[i]) + {ph7_reg[i], {CFG_W{1'b0}}};
            end
            len7_reg  <= len6_reg;
            tail7_reg <= '{pos: item6_reg.pos, apply: item6_reg.apply,
                           degen: item6_reg.degen};
            den8_reg  <= {len7_reg, {FRAC_BITS{1'b0}}};
            tail8_reg <= tail7_reg;
        end
    end

    // ---------------- divide ----------------
    logic               dv_vld;
    logic [2:0][QW-1:0] quo;
    tail_t              dv_tail;

    sfg_div #(
        .DENW (DENW),
        .QW   (QW),
        .PW   ($bits(tail_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v8_reg),
        .in_den    (den8_reg),
        .in_num    (num8_reg),
        .in_pay    (tail8_reg),
        .out_valid (dv_vld),
        .out_quo   (quo),
        .out_pay   (dv_tail)
    );

    // ---------------- saturate and output ----------------
    localparam logic [CW-1:0] F_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] F_MAX = {1'b0, {(CW-1){1'b1}}};

    vec_t force_next;
    logic m_valid_reg;
    vec_t force_reg;
    vec_t apply_reg;
    logic degen_reg;

    always_comb begin
        logic          big;
        logic [CW-1:0] lo;
        for (int i = 0; i < 3; i++) begin
            big = |quo[i][QW-1:CW-1];
            lo  = quo[i][CW-1:0];
            if (dv_tail.degen) begin
                force_next[i] = '0;
            end else if (dv_tail.pos[i]) begin
                force_next[i] = big ? F_MIN : CW'(-lo);
            end else begin
                force_next[i] = (big || (&lo[CW-2:0])) ? F_MAX : lo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            force_reg <= force_next;
            apply_reg <= dv_tail.apply;
            degen_reg <= dv_tail.degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_force_x    = force_reg[0];
    assign m_force_y    = force_reg[1];
    assign m_force_z    = force_reg[2];
    assign m_apply_x    = apply_reg[0];
    assign m_apply_y    = apply_reg[1];
    assign m_apply_z    = apply_reg[2];
    assign m_degenerate = degen_reg;

endmodule
`default_nettype wire

[rtl/core/sfg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfg_checker
// Port-level checks on the spring force generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "spring_force_generator_defines.svh"

module sfg_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic signed [COORD_WIDTH-1:0] m_force_x,
    input wire logic signed [COORD_WIDTH-1:0] m_force_y,
    input wire logic signed [COORD_WIDTH-1:0] m_force_z,
    input wire logic signed [COORD_WIDTH-1:0] m_apply_x,
    input wire logic                          m_degenerate
);

    `SFG_ASSERT_NXT(a_res_held, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped under stall")
    `SFG_ASSERT_NXT(a_res_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_force_x) && $stable(m_apply_x), "result changed under stall")
    `SFG_ASSERT_IMP(a_degen_zero, aclk, aresetn, m_valid && m_degenerate, m_force_x == '0 && m_force_y == '0 && m_force_z == '0, "coinciding ends gave nonzero force")
    `SFG_ASSERT_NXT(a_reset_clear, aclk, 1'b1, !aresetn, !m_valid && s_ready, "pipeline not empty after reset")

endmodule

bind spring_force_generator sfg_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sfg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_force_x    (m_force_x),
    .m_force_y    (m_force_y),
    .m_force_z    (m_force_z),
    .m_apply_x    (m_apply_x),
    .m_degenerate (m_degenerate)
);
`default_nettype wire
